// ===== hdl/sbeh_pkg.sv =====
package sbeh_pkg;

    localparam int ID_BITS_DEF   = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W   = 32;
    localparam int RADIUS_W  = 12;
    localparam int CFG_IDX_W = 3;
    // Grown corners and end points need two bits above a coordinate.
    localparam int GEOM_W    = COORD_W + 2;
    localparam int RECT_FLDS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd4;

    typedef enum logic [1:0] {
        FACE_LEFT,
        FACE_RIGHT,
        FACE_TOP,
        FACE_BOTTOM
    } face_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GROW,
        ST_CHECK,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic  load;
        logic  grow;
        logic  check;
        logic  div_start;
        logic  mul;
        logic  update;
        logic  emit;
        face_t face;
    } cmd_t;

    typedef struct packed {
        logic [3:0] face_mask;
        logic       last;
        logic       better;
        logic       div_done;
        logic       out_busy;
    } status_t;

endpackage

// ===== hdl/swept_box_earliest_hit.sv =====
// Finds where a point moving from (start_x, start_y) along (move_x, move_y) first crosses
// a face of any rectangle in a query, each rectangle grown by radius whole units on every
// side. Rectangles arrive one per transaction on the slave stream, tlast closing the query;
// one result per query leaves on the master stream, tuser carrying the hit flag. A
// rectangle is loaded, grown and checked, then its faces are scanned; each face it
// crosses (at most two) goes through the shared restoring divider, one quotient bit a
// cycle, and each new earliest crossing adds a multiply and an update. The rectangle
// closing a query then emits once the output is free, and no rectangle is taken before
// the last is done. Configuration writes take effect at once and belong between queries.
module swept_box_earliest_hit #(
    parameter int ID_BITS   = sbeh_pkg::ID_BITS_DEF,
    parameter int FRAC_BITS = sbeh_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // rect_left, rect_top, rect_right, rect_bottom, rect_id, zero padding
    input  logic [((sbeh_pkg::RECT_FLDS * sbeh_pkg::COORD_W + ID_BITS + 7) / 8) * 8 - 1:0]
                                                  s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // hit_fraction, point_x, point_y, normal_code, hit_id, zero padding
    output logic [((FRAC_BITS + 1 + 2 * sbeh_pkg::COORD_W + 2 + ID_BITS + 7) / 8) * 8 - 1:0]
                                                  m_tdata,
    // hit
    output logic                                  m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sbeh_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [sbeh_pkg::COORD_W-1:0]          cfg_data
);

    localparam int CW       = sbeh_pkg::COORD_W;
    localparam int OUT_USED = (FRAC_BITS + 1) + 2 * CW + 2 + ID_BITS;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

    logic signed [CW-1:0]                  start_x_reg, start_y_reg, move_x_reg, move_y_reg;
    logic        [sbeh_pkg::RADIUS_W-1:0]  radius_reg;

    sbeh_pkg::cmd_t    cmd;
    sbeh_pkg::status_t status;

    logic                  hit;
    logic [FRAC_BITS:0]    hit_fraction;
    logic signed [CW-1:0]  point_x, point_y;
    logic [1:0]            normal_code;
    logic [ID_BITS-1:0]    hit_id;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            move_x_reg  <= '0;
            move_y_reg  <= '0;
            radius_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                sbeh_pkg::CFG_START_X: start_x_reg <= cfg_data;
                sbeh_pkg::CFG_START_Y: start_y_reg <= cfg_data;
                sbeh_pkg::CFG_MOVE_X:  move_x_reg  <= cfg_data;
                sbeh_pkg::CFG_MOVE_Y:  move_y_reg  <= cfg_data;
                sbeh_pkg::CFG_RADIUS:  radius_reg  <= cfg_data[sbeh_pkg::RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sbeh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sbeh_dp #(
        .ID_BITS   (ID_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .start_x      (start_x_reg),
        .start_y      (start_y_reg),
        .move_x       (move_x_reg),
        .move_y       (move_y_reg),
        .radius       (radius_reg),
        .rect_left    ($signed(s_tdata[0*CW +: CW])),
        .rect_top     ($signed(s_tdata[1*CW +: CW])),
        .rect_right   ($signed(s_tdata[2*CW +: CW])),
        .rect_bottom  ($signed(s_tdata[3*CW +: CW])),
        .rect_id      (s_tdata[sbeh_pkg::RECT_FLDS*CW +: ID_BITS]),
        .last_rect    (s_tlast),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .hit          (hit),
        .hit_fraction (hit_fraction),
        .point_x      (point_x),
        .point_y      (point_y),
        .normal_code  (normal_code),
        .hit_id       (hit_id)
    );

    assign m_tdata = OUT_W'({hit_id, normal_code, point_y, point_x, hit_fraction});
    assign m_tuser = hit;

endmodule

// ===== hdl/sbeh_div.sv =====
module sbeh_div #(
    parameter int FRAC_BITS = sbeh_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [sbeh_pkg::COORD_W-1:0] num,
    input  logic [sbeh_pkg::COORD_W-1:0] den,
    output logic [FRAC_BITS-1:0]         quo,
    output logic                         done
);

    localparam int CW   = sbeh_pkg::COORD_W;
    localparam int CNTW = $clog2(FRAC_BITS + 1);

    logic [CW-1:0]        rem_reg;
    logic [CW-1:0]        den_reg;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic                 done_reg;

    logic [CW:0] rem2;
    logic [CW:0] diff;
    logic        ge;

    // The numerator is always below the divisor, so the remainder stays below it too
    // and one bit of headroom is enough for the doubled remainder.
    assign rem2 = {rem_reg, 1'b0};
    assign diff = rem2 - {1'b0, den_reg};
    assign ge   = (rem2 >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNTW'(FRAC_BITS);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[CW-1:0] : rem2[CW-1:0];
            quo_reg <= {quo_reg[FRAC_BITS-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ===== hdl/sbeh_ctrl.sv =====
module sbeh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sbeh_pkg::status_t status,
    output sbeh_pkg::cmd_t    cmd
);

    sbeh_pkg::state_t state_reg;
    sbeh_pkg::state_t state_next;
    sbeh_pkg::face_t  face_reg;
    sbeh_pkg::face_t  face_next;
    sbeh_pkg::state_t after_faces;

    // Once the bottom face is done the rectangle is finished.
    assign after_faces = status.last ? sbeh_pkg::ST_EMIT : sbeh_pkg::ST_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbeh_pkg::ST_IDLE;
            face_reg  <= sbeh_pkg::FACE_LEFT;
        end else begin
            state_reg <= state_next;
            face_reg  <= face_next;
        end
    end

    always_comb begin
        logic advance;
        advance    = 1'b0;
        state_next = state_reg;
        face_next  = face_reg;
        case (state_reg)
            sbeh_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = sbeh_pkg::ST_GROW;
                end
            end
            sbeh_pkg::ST_GROW: begin
                state_next = sbeh_pkg::ST_CHECK;
            end
            sbeh_pkg::ST_CHECK: begin
                state_next = sbeh_pkg::ST_SCAN;
                face_next  = sbeh_pkg::FACE_LEFT;
            end
            sbeh_pkg::ST_SCAN: begin
                if (status.face_mask[face_reg]) begin
                    state_next = sbeh_pkg::ST_DIV;
                end else begin
                    advance = 1'b1;
                end
            end
            sbeh_pkg::ST_DIV: begin
                if (status.div_done) begin
                    if (status.better) begin
                        state_next = sbeh_pkg::ST_MUL;
                    end else begin
                        advance = 1'b1;
                    end
                end
            end
            sbeh_pkg::ST_MUL: begin
                state_next = sbeh_pkg::ST_UPDATE;
            end
            sbeh_pkg::ST_UPDATE: begin
                advance = 1'b1;
            end
            sbeh_pkg::ST_EMIT: begin
                if (!status.out_busy) begin
                    state_next = sbeh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbeh_pkg::ST_IDLE;
            end
        endcase
        if (advance) begin
            if (face_reg == sbeh_pkg::FACE_BOTTOM) begin
                state_next = after_faces;
            end else begin
                state_next = sbeh_pkg::ST_SCAN;
                face_next  = sbeh_pkg::face_t'(face_reg + 2'd1);
            end
        end
    end

    always_comb begin
        cmd      = '0;
        cmd.face = face_reg;
        in_ready = 1'b0;
        case (state_reg)
            sbeh_pkg::ST_IDLE: begin
                // No transaction is taken while reset is held.
                in_ready = aresetn;
                cmd.load = in_valid && aresetn;
            end
            sbeh_pkg::ST_GROW: begin
                cmd.grow = 1'b1;
            end
            sbeh_pkg::ST_CHECK: begin
                cmd.check = 1'b1;
            end
            sbeh_pkg::ST_SCAN: begin
                cmd.div_start = status.face_mask[face_reg];
            end
            sbeh_pkg::ST_MUL: begin
                cmd.mul = 1'b1;
            end
            sbeh_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            sbeh_pkg::ST_EMIT: begin
                cmd.emit = !status.out_busy;
            end
            default: begin
                cmd.face = face_reg;
            end
        endcase
    end

endmodule

// ===== hdl/sbeh_dp.sv =====
module sbeh_dp #(
    parameter int ID_BITS   = sbeh_pkg::ID_BITS_DEF,
    parameter int FRAC_BITS = sbeh_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sbeh_pkg::cmd_t                       cmd,
    output sbeh_pkg::status_t                    status,
    input  logic signed [sbeh_pkg::COORD_W-1:0]  start_x,
    input  logic signed [sbeh_pkg::COORD_W-1:0]  start_y,
    input  logic signed [sbeh_pkg::COORD_W-1:0]  move_x,
    input  logic signed [sbeh_pkg::COORD_W-1:0]  move_y,
    input  logic        [sbeh_pkg::RADIUS_W-1:0] radius,
    input  logic signed [sbeh_pkg::COORD_W-1:0]  rect_left,
    input  logic signed [sbeh_pkg::COORD_W-1:0]  rect_top,
    input  logic signed [sbeh_pkg::COORD_W-1:0]  rect_right,
    input  logic signed [sbeh_pkg::COORD_W-1:0]  rect_bottom,
    input  logic        [ID_BITS-1:0]            rect_id,
    input  logic                                 last_rect,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 hit,
    output logic        [FRAC_BITS:0]            hit_fraction,
    output logic signed [sbeh_pkg::COORD_W-1:0]  point_x,
    output logic signed [sbeh_pkg::COORD_W-1:0]  point_y,
    output logic        [1:0]                    normal_code,
    output logic        [ID_BITS-1:0]            hit_id
);

    localparam int CW = sbeh_pkg::COORD_W;
    localparam int GW = sbeh_pkg::GEOM_W;
    localparam int PW = FRAC_BITS + CW + 1;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [GW-1:0] v);
        logic signed [CW-1:0] r;
        if (v[GW-1:CW-1] == '0 || v[GW-1:CW-1] == '1) begin
            r = v[CW-1:0];
        end else if (v[GW-1]) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    logic signed [CW-1:0]   left_reg, top_reg, right_reg, bottom_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic                   last_reg;
    logic signed [GW-1:0]   ulx_reg, uly_reg, lrx_reg, lry_reg, ex_reg, ey_reg;
    logic [3:0]             mask_reg;
    logic signed [PW-1:0]   prod_x_reg, prod_y_reg;
    logic                   found_reg;
    logic [FRAC_BITS-1:0]   best_frac_reg;
    logic signed [CW-1:0]   best_px_reg, best_py_reg;
    sbeh_pkg::face_t        best_normal_reg;
    logic [ID_BITS-1:0]     best_id_reg;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [FRAC_BITS:0]     out_frac_reg;
    logic signed [CW-1:0]   out_px_reg, out_py_reg;
    logic [1:0]             out_normal_reg;
    logic [ID_BITS-1:0]     out_id_reg;

    logic signed [GW-1:0]   grow_s, bx, by;
    logic                   y_overlap, x_overlap;
    logic [3:0]             mask_next;
    logic signed [GW-1:0]   num_w;
    logic [CW-1:0]          den_w;
    logic signed [CW:0]     neg_mx, neg_my;
    logic [FRAC_BITS-1:0]   quo;
    logic                   div_done;
    logic signed [FRAC_BITS:0] quo_s;
    logic signed [CW:0]     shift_x, shift_y;
    logic signed [GW-1:0]   sum_x, sum_y;

    assign grow_s = $signed({{(GW - sbeh_pkg::RADIUS_W - 16){1'b0}}, radius, 16'b0});
    assign bx     = GW'(start_x);
    assign by     = GW'(start_y);

    // A face only counts when the segment is not wholly beyond the other axis.
    assign y_overlap = !((by > lry_reg && ey_reg > lry_reg) || (by < uly_reg && ey_reg < uly_reg));
    assign x_overlap = !((bx > lrx_reg && ex_reg > lrx_reg) || (bx < ulx_reg && ex_reg < ulx_reg));

    always_comb begin
        mask_next[sbeh_pkg::FACE_LEFT]   = y_overlap && bx < ulx_reg && ex_reg > ulx_reg;
        mask_next[sbeh_pkg::FACE_RIGHT]  = y_overlap && bx > lrx_reg && ex_reg < lrx_reg;
        mask_next[sbeh_pkg::FACE_TOP]    = x_overlap && by < uly_reg && ey_reg > uly_reg;
        mask_next[sbeh_pkg::FACE_BOTTOM] = x_overlap && by > lry_reg && ey_reg < lry_reg;
    end

    assign neg_mx = -((CW+1)'(move_x));
    assign neg_my = -((CW+1)'(move_y));

    // Distance to the face line over the magnitude of the move component.
    always_comb begin
        case (cmd.face)
            sbeh_pkg::FACE_LEFT: begin
                num_w = ulx_reg - bx;
                den_w = move_x;
            end
            sbeh_pkg::FACE_RIGHT: begin
                num_w = bx - lrx_reg;
                den_w = neg_mx[CW-1:0];
            end
            sbeh_pkg::FACE_TOP: begin
                num_w = uly_reg - by;
                den_w = move_y;
            end
            sbeh_pkg::FACE_BOTTOM: begin
                num_w = by - lry_reg;
                den_w = neg_my[CW-1:0];
            end
            default: begin
                num_w = '0;
                den_w = '1;
            end
        endcase
    end

    sbeh_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_w[CW-1:0]),
        .den     (den_w),
        .quo     (quo),
        .done    (div_done)
    );

    assign quo_s = $signed({1'b0, quo});

    // The arithmetic shift rounds toward minus infinity.
    assign shift_x = $signed(prod_x_reg[PW-1:FRAC_BITS]);
    assign shift_y = $signed(prod_y_reg[PW-1:FRAC_BITS]);
    assign sum_x   = GW'(shift_x) + GW'(start_x);
    assign sum_y   = GW'(shift_y) + GW'(start_y);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            left_reg   <= rect_left;
            top_reg    <= rect_top;
            right_reg  <= rect_right;
            bottom_reg <= rect_bottom;
            id_reg     <= rect_id;
            last_reg   <= last_rect;
        end
        if (cmd.grow) begin
            ulx_reg <= GW'(left_reg) - grow_s;
            uly_reg <= GW'(top_reg) - grow_s;
            lrx_reg <= GW'(right_reg) + grow_s;
            lry_reg <= GW'(bottom_reg) + grow_s;
            ex_reg  <= GW'(start_x) + GW'(move_x);
            ey_reg  <= GW'(start_y) + GW'(move_y);
        end
        if (cmd.check) begin
            mask_reg <= mask_next;
        end
        if (cmd.mul) begin
            prod_x_reg <= PW'(quo_s) * PW'(move_x);
            prod_y_reg <= PW'(quo_s) * PW'(move_y);
        end
        if (cmd.update) begin
            best_frac_reg   <= quo;
            best_px_reg     <= sat_coord(sum_x);
            best_py_reg     <= sat_coord(sum_y);
            best_normal_reg <= cmd.face;
            best_id_reg     <= id_reg;
        end
        if (cmd.emit) begin
            out_hit_reg    <= found_reg;
            out_frac_reg   <= found_reg ? {1'b0, best_frac_reg} : '0;
            out_px_reg     <= found_reg ? best_px_reg : '0;
            out_py_reg     <= found_reg ? best_py_reg : '0;
            out_normal_reg <= found_reg ? best_normal_reg : 2'd0;
            out_id_reg     <= found_reg ? best_id_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.update) begin
                found_reg <= 1'b1;
            end else if (cmd.emit) begin
                found_reg <= 1'b0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status.face_mask = mask_reg;
        status.last      = last_reg;
        status.better    = !found_reg || (quo < best_frac_reg);
        status.div_done  = div_done;
        status.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign hit_fraction = out_frac_reg;
    assign point_x      = out_px_reg;
    assign point_y      = out_py_reg;
    assign normal_code  = out_normal_reg;
    assign hit_id       = out_id_reg;

endmodule

// ===== sim/tb.sv =====
module tb;

    localparam int SD_W   = 144;  // four corners and an id, already whole bytes
    localparam int MD_W   = 104;  // 99 bits of result padded up to whole bytes
    localparam int FRAC   = 16;
    localparam int U      = 65536;  // one whole unit in Q16.16
    localparam int SETTLE = 64;     // a little more than the slowest rectangle
    localparam int ITEMS  = 1350;

    typedef struct packed {
        logic              hit;
        logic [16:0]       frac;
        logic [31:0]       px;
        logic [31:0]       py;
        sbeh_pkg::face_t   normal;
        logic [15:0]       id;
    } hit_rec_t;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] rad;
        logic [31:0] l;
        logic [31:0] t;
        logic [31:0] r;
        logic [31:0] b;
        logic [15:0] id;
        logic        last;
        logic        typed;
        hit_rec_t    want;
    } probe_row_t;

    localparam hit_rec_t NO_HIT = '0;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [SD_W-1:0]                s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [MD_W-1:0]                m_tdata;
    logic                           m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sbeh_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [sbeh_pkg::COORD_W-1:0]   cfg_data = '0;

    swept_box_earliest_hit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Mover settings as the block holds them.
    longint      mv_sx = 0, mv_sy = 0, mv_mx = 0, mv_my = 0;
    logic [11:0] mv_rad = '0;

    // Best crossing of the query under way.
    bit              run_found = 1'b0;
    logic [16:0]     run_frac = '0;
    logic [31:0]     run_px = '0, run_py = '0;
    sbeh_pkg::face_t run_face = sbeh_pkg::FACE_LEFT;
    logic [15:0]     run_id = '0;

    hit_rec_t    hits_due[$];
    probe_row_t  probe_rows[$];
    int          bad = 0;
    int          hits_taken = 0;
    int          items_sent = 0;

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // num and den are both positive with num below den, so the quotient is under one.
    function automatic void try_face(longint num, longint den, sbeh_pkg::face_t f,
                                     logic [15:0] id);
        longint q;
        q = (num <<< FRAC) / den;
        if (run_found && !(q < longint'(run_frac)))
            return;
        run_found = 1'b1;
        run_frac  = q[16:0];
        run_px    = clamp32(mv_sx + ((q * mv_mx) >>> FRAC));
        run_py    = clamp32(mv_sy + ((q * mv_my) >>> FRAC));
        run_face  = f;
        run_id    = id;
    endfunction

    function automatic bit sweep_rect(int l, int t, int r, int b, logic [15:0] id,
                                      bit last, output hit_rec_t res);
        longint grow, ulx, uly, lrx, lry, ex, ey;
        grow = longint'(mv_rad) <<< 16;
        ulx  = longint'(l) - grow;
        uly  = longint'(t) - grow;
        lrx  = longint'(r) + grow;
        lry  = longint'(b) + grow;
        ex   = mv_sx + mv_mx;
        ey   = mv_sy + mv_my;
        res  = NO_HIT;
        if (!((mv_sy > lry && ey > lry) || (mv_sy < uly && ey < uly))) begin
            if (mv_sx < ulx && ex > ulx)
                try_face(ulx - mv_sx, mv_mx, sbeh_pkg::FACE_LEFT, id);
            if (mv_sx > lrx && ex < lrx)
                try_face(mv_sx - lrx, -mv_mx, sbeh_pkg::FACE_RIGHT, id);
        end
        if (!((mv_sx > lrx && ex > lrx) || (mv_sx < ulx && ex < ulx))) begin
            if (mv_sy < uly && ey > uly)
                try_face(uly - mv_sy, mv_my, sbeh_pkg::FACE_TOP, id);
            if (mv_sy > lry && ey < lry)
                try_face(mv_sy - lry, -mv_my, sbeh_pkg::FACE_BOTTOM, id);
        end
        if (!last)
            return 1'b0;
        res = '{run_found, run_frac, run_px, run_py, run_face, run_id};
        run_found = 1'b0;
        run_frac  = '0;
        run_px    = '0;
        run_py    = '0;
        run_face  = sbeh_pkg::FACE_LEFT;
        run_id    = '0;
        return 1'b1;
    endfunction

    function automatic int pick_gap(bit quiet);
        int sel;
        sel = $urandom_range(0, 99);
        if (quiet || sel < 60)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_rect(int l, int t, int r, int b, logic [15:0] id, bit last,
                             bit typed, hit_rec_t want, bit quiet);
        int       gap;
        hit_rec_t got;
        gap = pick_gap(quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {id, b, r, t, l};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (sweep_rect(l, t, r, b, id, last, got))
            hits_due.push_back(typed ? want : got);
    endtask

    task automatic write_reg(logic [sbeh_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            sbeh_pkg::CFG_START_X: mv_sx = longint'(signed'(val));
            sbeh_pkg::CFG_START_Y: mv_sy = longint'(signed'(val));
            sbeh_pkg::CFG_MOVE_X:  mv_mx = longint'(signed'(val));
            sbeh_pkg::CFG_MOVE_Y:  mv_my = longint'(signed'(val));
            sbeh_pkg::CFG_RADIUS:  mv_rad = val[11:0];
            default: ;
        endcase
    endtask

    task automatic load_mover(logic [31:0] sx, logic [31:0] sy, logic [31:0] mx,
                              logic [31:0] my, logic [31:0] rad);
        write_reg(sbeh_pkg::CFG_START_X, sx);
        write_reg(sbeh_pkg::CFG_START_Y, sy);
        write_reg(sbeh_pkg::CFG_MOVE_X, mx);
        write_reg(sbeh_pkg::CFG_MOVE_Y, my);
        write_reg(sbeh_pkg::CFG_RADIUS, rad);
        cfg_valid <= 1'b0;
    endtask

    // Every result in, then long enough for any rectangle still in the divider.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (hits_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic add_row(int sx, int sy, int mx, int my, int rad, int l, int t, int r,
                           int b, int id, bit last, bit typed, hit_rec_t want);
        probe_row_t row;
        row = '{sx, sy, mx, my, rad, l, t, r, b, id[15:0], last, typed, want};
        probe_rows.push_back(row);
    endtask

    function automatic int pick_edge();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int near_span(longint c);
        return int'(c);
    endfunction

    task automatic random_phase();
        int     sel, n, qleft, l, t, r, b, tmp;
        bit     quiet, last;
        longint cx, cy;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            load_mover($urandom_range(0, 200 * U) - 100 * U, $urandom_range(0, 200 * U) - 100 * U,
                       ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 400 * U) - 200 * U,
                       ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 400 * U) - 200 * U,
                       $urandom_range(0, 8));
        end else if (sel < 85) begin
            load_mover($urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            load_mover(pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                       $urandom_range(0, 1) ? 32'd4095 : 32'd0);
        end
        n     = $urandom_range(20, 40);
        quiet = ($urandom_range(0, 4) == 0);
        qleft = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                l = $urandom;
                t = $urandom;
                r = $urandom;
                b = $urandom;
            end else begin
                tmp = $urandom_range(0, 1200);
                cx  = mv_sx + mv_mx * tmp / 1000;
                if ($urandom_range(0, 3) == 0)
                    tmp = $urandom_range(0, 1200);
                cy  = mv_sy + mv_my * tmp / 1000;
                l   = near_span(cx - $urandom_range(0, 30 * U));
                r   = near_span(cx + $urandom_range(0, 30 * U));
                t   = near_span(cy - $urandom_range(0, 30 * U));
                b   = near_span(cy + $urandom_range(0, 30 * U));
                if (sel < 18) begin
                    tmp = l;
                    l   = r;
                    r   = tmp;
                end else if (sel < 24) begin
                    tmp = t;
                    t   = b;
                    b   = tmp;
                end
            end
            last = (qleft == 1) || (i == n - 1);
            send_rect(l, t, r, b, $urandom, last, 1'b0, NO_HIT, quiet);
            qleft--;
            if (last)
                qleft = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20)
                                                    : $urandom_range(1, 6);
        end
        settle();
    endtask

    // Receiver: mostly short gaps, twice a long hold-off so that the block backs up.
    initial begin
        int hold_mark;
        int holds;
        int len;
        bit on;
        hold_mark = 25;
        holds     = 0;
        forever begin
            if (holds < 2 && hits_taken >= hold_mark) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                holds++;
                hold_mark = hits_taken + 300;
            end else begin
                on = ($urandom_range(0, 99) < 70);
                m_tready <= on;
                if (on)
                    len = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(1, 20);
                else
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 3);
                repeat (len) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        hit_rec_t seen;
        hit_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = '{m_tuser, m_tdata[16:0], m_tdata[48:17], m_tdata[80:49],
                     sbeh_pkg::face_t'(m_tdata[82:81]), m_tdata[98:83]};
            hits_taken++;
            if (hits_due.size() == 0) begin
                $error("result transaction with no query outstanding");
                bad++;
            end else begin
                want = hits_due.pop_front();
                if (seen.hit !== want.hit) begin
                    $error("hit: expected %0h, got %0h", want.hit, seen.hit);
                    bad++;
                end
                if (seen.frac !== want.frac) begin
                    $error("hit_fraction: expected %0h, got %0h", want.frac, seen.frac);
                    bad++;
                end
                if (seen.px !== want.px) begin
                    $error("point_x: expected %0h, got %0h", want.px, seen.px);
                    bad++;
                end
                if (seen.py !== want.py) begin
                    $error("point_y: expected %0h, got %0h", want.py, seen.py);
                    bad++;
                end
                if (seen.normal !== want.normal) begin
                    $error("normal_code: expected %0h, got %0h", want.normal, seen.normal);
                    bad++;
                end
                if (seen.id !== want.id) begin
                    $error("hit_id: expected %0h, got %0h", want.id, seen.id);
                    bad++;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        probe_row_t row;
        // Settings straight from reset: no move, so nothing can be crossed.
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, NO_HIT);
        add_row(0, 0, 10 * U, 0, 0, 5 * U, -U, 8 * U, U, 7, 1, 1,
                '{1'b1, 17'h8000, 32'h0005_0000, 32'h0, sbeh_pkg::FACE_LEFT, 16'd7});
        // The end point sits exactly on the face line, which is not a crossing.
        add_row(0, 0, 10 * U, 0, 0, 10 * U, -U, 12 * U, U, 11, 1, 1, NO_HIT);
        // The whole move passes above the rectangle.
        add_row(0, 0, 10 * U, 0, 0, 5 * U, 2 * U, 8 * U, 3 * U, 12, 1, 1, NO_HIT);
        add_row(0, 0, 10 * U, 0, 0, 8 * U, -U, 5 * U, U, 13, 1, 0, NO_HIT);
        add_row(0, 0, 10 * U, 0, 0, 7 * U, -U, 9 * U, U, 20, 0, 0, NO_HIT);
        add_row(0, 0, 10 * U, 0, 0, 3 * U, -U, 4 * U, U, 21, 0, 0, NO_HIT);
        add_row(0, 0, 10 * U, 0, 0, 5 * U, 5 * U, 6 * U, 6 * U, 22, 1, 0, NO_HIT);
        add_row(0, 0, -10 * U, 0, 0, -8 * U, -U, -5 * U, U, 8, 1, 1,
                '{1'b1, 17'h8000, 32'hFFFB_0000, 32'h0, sbeh_pkg::FACE_RIGHT, 16'd8});
        add_row(0, 0, 0, 10 * U, 0, -U, 4 * U, U, 6 * U, 9, 1, 0, NO_HIT);
        add_row(0, 0, 0, -10 * U, 0, -U, -6 * U, U, -4 * U, 10, 1, 0, NO_HIT);
        // Equal fractions on two faces and then on a second rectangle: the first one stays.
        add_row(0, 0, 10 * U, 10 * U, 0, 5 * U, 5 * U, 8 * U, 8 * U, 1, 0, 0, NO_HIT);
        add_row(0, 0, 10 * U, 10 * U, 0, 5 * U, -20 * U, 30 * U, 30 * U, 3, 1, 1,
                '{1'b1, 17'h8000, 32'h0005_0000, 32'h0005_0000, sbeh_pkg::FACE_LEFT,
                  16'd1});
        add_row(-5000 * U, 0, 10000 * U, 0, 4095, 0, 0, 0, 0, 16'hFFFF, 1, 0, NO_HIT);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                32'hC000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1234, 1, 0,
                NO_HIT);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 4095,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h5AA5, 1, 0,
                NO_HIT);
        // Grown corners run past the 32-bit range here.
        add_row(0, 0, 32'h7FFF_FFFF, 0, 4095, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 16'hA55A, 0, 0, NO_HIT);
        add_row(0, 0, 32'h7FFF_FFFF, 0, 4095, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 0, 1, 0, NO_HIT);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probe_rows[i]) begin
            row = probe_rows[i];
            if (longint'(signed'(row.sx)) != mv_sx || longint'(signed'(row.sy)) != mv_sy ||
                longint'(signed'(row.mx)) != mv_mx || longint'(signed'(row.my)) != mv_my ||
                row.rad[11:0] != mv_rad) begin
                settle();
                load_mover(row.sx, row.sy, row.mx, row.my, row.rad);
            end
            send_rect(row.l, row.t, row.r, row.b, row.id, row.last, row.typed, row.want,
                      1'b0);
        end
        settle();

        while (items_sent < ITEMS)
            random_phase();

        settle();
        if (bad == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/sbeh_pkg.sv
hdl/sbeh_div.sv
hdl/sbeh_ctrl.sv
hdl/sbeh_dp.sv
hdl/swept_box_earliest_hit.sv
sim/tb.sv
